>>> hdl/grn_pkg.sv
package grn_pkg;

  localparam int unsigned MAX_ROW_LENGTH = 8192;
  localparam int unsigned ROW_CAP = (MAX_ROW_LENGTH < 16383) ? MAX_ROW_LENGTH : 16383;
  localparam int unsigned CNT_W = 14;
  localparam int unsigned TAYLOR_TERMS = 24;
  localparam int unsigned SQUARINGS = 5;
  localparam int unsigned FIN_TOP_BIT = 31;
  localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;
  localparam logic [19:0] EPS_RESET = 20'd4;

  typedef enum logic {
    OPER_ACCUM = 1'b0,
    OPER_APPLY = 1'b1
  } oper_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FIN_INIT,
    S_FIN_SQ,
    S_FIN_MGO,
    S_FIN_MW,
    S_FIN_CMP,
    S_FIN_END,
    S_XW,
    S_NORM,
    S_TAY_MGO,
    S_TAY_MW,
    S_TAY_DGO,
    S_TAY_DW,
    S_TAY_UPD,
    S_SQ_MGO,
    S_SQ_MW,
    S_SQ_UPD,
    S_SIG_DGO,
    S_SIG_DW,
    S_SIL_MGO,
    S_SIL_MW,
    S_SMAG,
    S_OUT_MGO,
    S_OUT_MW,
    S_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_LOAD,
    OP_FIN_INIT,
    OP_FIN_SQ,
    OP_FIN_CMP,
    OP_FIN_END,
    OP_XW,
    OP_NORM,
    OP_TAY_UPD,
    OP_SQ_UPD,
    OP_SMAG,
    OP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    MS_FIN,
    MS_TAY,
    MS_SQ,
    MS_SIL,
    MS_FINAL
  } mul_sel_e;

  typedef enum logic {
    DS_TAY,
    DS_SIG
  } div_sel_e;

  typedef struct packed {
    dp_op_e     op;
    logic       mul_start;
    mul_sel_e   mul_sel;
    logic       div_start;
    div_sel_e   div_sel;
    logic [4:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/grn_in_if.sv
interface grn_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] x_value;
  logic [15:0] gate_value;
  logic [15:0] weight_value;
  logic        last;

  modport source (output valid, operation, x_value, gate_value, weight_value, last,
                  input ready);
  modport sink (input valid, operation, x_value, gate_value, weight_value, last,
                output ready);
endinterface

>>> hdl/grn_out_if.sv
interface grn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_value;
  logic        saturated;

  modport source (output valid, result_value, saturated, input ready);
  modport sink (input valid, result_value, saturated, output ready);
endinterface

>>> hdl/grn_cfg_if.sv
interface grn_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hdl/grn_mul.sv
// 64x64 unsigned multiply, one 32x32 partial product per cycle
module grn_mul
  import grn_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic [127:0]  prod_o,
  output logic          busy_o,
  output logic          done_o
);

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   step_q;
  logic         busy_q, done_q;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    opa = step_q[1] ? a_q[63:32] : a_q[31:0];
    opb = (step_q == 2'd1 || step_q == 2'd3) ? b_q[63:32] : b_q[31:0];
    pp  = opa * opb;
    unique case (step_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    acc_d = acc_q + pp_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = acc_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

>>> hdl/grn_div.sv
// 128/64 restoring divider, one quotient bit per cycle; needs num_hi < den
module grn_div
  import grn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_hi_i,
  input  logic [63:0] num_lo_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o,
  output logic        busy_o,
  output logic        done_o
);

  logic [63:0] rem_q, lo_q, den_q, quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [63:0] rsh;
  logic        ge;

  always_comb begin
    rsh = {rem_q[62:0], lo_q[63]};
    ge  = rem_q[63] || (rsh >= den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi_i;
      lo_q  <= num_lo_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rsh - den_q) : rsh;
      lo_q  <= {lo_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

>>> hdl/grn_datapath.sv
module grn_datapath
  import grn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] z_i,
  input  logic signed [15:0] w_i,
  input  logic               cfg_we_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [15:0]        result_o,
  output logic               saturated_o
);

  logic [19:0]        eps_q;
  logic [47:0]        sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [31:0]        inv_q;
  logic signed [15:0] x_q, z_q, w_q;
  logic [47:0]        ms_q;
  logic [31:0]        v_q;
  logic [63:0]        cc_q;
  logic [30:0]        xwm_q;
  logic               neg_q;
  logic [15:0]        t_q;
  logic [61:0]        normed_q;
  logic [63:0]        term_q, esum_q;
  logic [44:0]        smag_q;
  logic               out_valid_q;
  logic [15:0]        result_q;
  logic               sat_q;

  logic               mul_start, mul_busy, mul_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       prod;
  logic               div_start, div_busy, div_done;
  logic [63:0]        div_hi, div_lo, div_den, quo;
  logic [63:0]        sig_num;

  logic signed [31:0] xsq, xw;
  logic [31:0]        cand;
  logic [62:0]        normed_full;
  logic [77:0]        smag_sum;
  logic [44:0]        qsum;
  logic [37:0]        q;
  logic [16:0]        qs;
  logic               q_neg, q_sat;
  logic [15:0]        z_neg;

  assign mul_start = cmd_i.mul_start;
  assign div_start = cmd_i.div_start;
  assign sig_num   = z_q[15] ? esum_q : ONE62;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_FIN:   begin mul_a = cc_q;             mul_b = {16'd0, ms_q};          end
      MS_TAY:   begin mul_a = term_q;           mul_b = {2'd0, t_q, 46'd0};     end
      MS_SQ:    begin mul_a = esum_q;           mul_b = esum_q;                 end
      MS_SIL:   begin mul_a = {48'd0, t_q};     mul_b = quo;                    end
      MS_FINAL: begin mul_a = {2'd0, normed_q}; mul_b = {19'd0, smag_q};        end
      default:  begin mul_a = cc_q;             mul_b = {16'd0, ms_q};          end
    endcase
    unique case (cmd_i.div_sel)
      DS_TAY: begin
        div_hi  = '0;
        div_lo  = prod[125:62];
        div_den = {59'd0, cmd_i.idx};
      end
      DS_SIG: begin
        div_hi  = {2'd0, sig_num[63:2]};
        div_lo  = {sig_num[1:0], 62'd0};
        div_den = ONE62 + esum_q;
      end
      default: begin
        div_hi  = '0;
        div_lo  = prod[125:62];
        div_den = {59'd0, cmd_i.idx};
      end
    endcase
  end

  grn_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .busy_o  (mul_busy),
    .done_o  (mul_done)
  );

  grn_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (div_hi),
    .num_lo_i (div_lo),
    .den_i    (div_den),
    .quo_o    (quo),
    .busy_o   (div_busy),
    .done_o   (div_done)
  );

  always_comb begin
    xsq         = x_i * x_i;
    xw          = x_q * w_q;
    cand        = v_q | (32'd1 << cmd_i.idx);
    normed_full = {32'd0, xwm_q} * {31'd0, inv_q};
    smag_sum    = prod[77:0] + 78'h1_0000_0000;
    qsum        = {1'b0, prod[107:64]} + 45'd64;
    q           = qsum[44:7];
    z_neg       = 16'(~z_q) + 16'd1;
    q_neg       = neg_q && (q != '0);
    if (!q_neg) begin
      q_sat = (q > 38'd32767);
      qs    = q_sat ? 17'd32767 : q[16:0];
    end else begin
      q_sat = (q > 38'd32768);
      qs    = q_sat ? 17'd32768 : q[16:0];
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q       <= EPS_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      inv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eps_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_ACC && cnt_q < CNT_W'(ROW_CAP)) begin
        sum_q <= sum_q + {16'd0, xsq};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.op == OP_FIN_END) begin
        inv_q <= v_q;
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q <= x_i;
        z_q <= z_i;
        w_q <= w_i;
      end
      OP_FIN_INIT: begin
        // epsilon * count needs the full 34 bits
        ms_q <= sum_q + {14'd0, {14'd0, eps_q} * {20'd0, cnt_q}};
        v_q  <= '0;
      end
      OP_FIN_SQ: cc_q <= cand * cand;
      OP_FIN_CMP: begin
        if (prod[127:76] == '0 && prod[75:0] <= {cnt_q, 62'd0}) begin
          v_q <= cand;
        end
      end
      OP_XW: begin
        xwm_q  <= xw[31] ? 31'(-xw) : 31'(xw);
        neg_q  <= xw[31] != z_q[15];
        t_q    <= z_q[15] ? z_neg : z_q;
        term_q <= ONE62;
        esum_q <= ONE62;
      end
      OP_NORM: normed_q <= normed_full[61:0];
      OP_TAY_UPD: begin
        term_q <= quo;
        esum_q <= cmd_i.idx[0] ? (esum_q - quo) : (esum_q + quo);
      end
      OP_SQ_UPD: esum_q <= prod[125:62];
      OP_SMAG:   smag_q <= smag_sum[77:33];
      OP_OUT: begin
        result_q <= q_neg ? 16'(17'd0 - qs) : qs[15:0];
        sat_q    <= q_sat;
      end
      default: ;
    endcase
  end

  assign stat_o = '{mul_busy: mul_busy, mul_done: mul_done, div_busy: div_busy,
                    div_done: div_done, out_free: !out_valid_q || out_ready_i};
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign saturated_o = sat_q;

endmodule

>>> hdl/grn_ctrl.sv
module grn_ctrl
  import grn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [4:0]  idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OPER_APPLY) begin
            state_d = S_XW;
          end else if (in_last_i) begin
            state_d = S_FIN_INIT;
          end
        end
      end
      S_FIN_INIT: begin
        idx_d   = 5'(FIN_TOP_BIT);
        state_d = S_FIN_SQ;
      end
      S_FIN_SQ:  state_d = S_FIN_MGO;
      S_FIN_MGO: state_d = S_FIN_MW;
      S_FIN_MW:  if (stat_i.mul_done) state_d = S_FIN_CMP;
      S_FIN_CMP: begin
        if (idx_q == '0) begin
          state_d = S_FIN_END;
        end else begin
          idx_d   = idx_q - 5'd1;
          state_d = S_FIN_SQ;
        end
      end
      S_FIN_END: state_d = S_IDLE;
      S_XW:      state_d = S_NORM;
      S_NORM: begin
        idx_d   = 5'd1;
        state_d = S_TAY_MGO;
      end
      S_TAY_MGO: state_d = S_TAY_MW;
      S_TAY_MW:  if (stat_i.mul_done) state_d = S_TAY_DGO;
      S_TAY_DGO: state_d = S_TAY_DW;
      S_TAY_DW:  if (stat_i.div_done) state_d = S_TAY_UPD;
      S_TAY_UPD: begin
        if (idx_q == 5'(TAYLOR_TERMS)) begin
          idx_d   = '0;
          state_d = S_SQ_MGO;
        end else begin
          idx_d   = idx_q + 5'd1;
          state_d = S_TAY_MGO;
        end
      end
      S_SQ_MGO: state_d = S_SQ_MW;
      S_SQ_MW:  if (stat_i.mul_done) state_d = S_SQ_UPD;
      S_SQ_UPD: begin
        if (idx_q == 5'(SQUARINGS - 1)) begin
          state_d = S_SIG_DGO;
        end else begin
          idx_d   = idx_q + 5'd1;
          state_d = S_SQ_MGO;
        end
      end
      S_SIG_DGO: state_d = S_SIG_DW;
      S_SIG_DW:  if (stat_i.div_done) state_d = S_SIL_MGO;
      S_SIL_MGO: state_d = S_SIL_MW;
      S_SIL_MW:  if (stat_i.mul_done) state_d = S_SMAG;
      S_SMAG:    state_d = S_OUT_MGO;
      S_OUT_MGO: state_d = S_OUT_MW;
      S_OUT_MW:  if (stat_i.mul_done) state_d = S_OUT;
      S_OUT:     if (stat_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '{op: OP_NONE, mul_start: 1'b0, mul_sel: MS_FIN, div_start: 1'b0,
                   div_sel: DS_TAY, idx: idx_q};
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = (in_op_i == OPER_APPLY) ? OP_LOAD : OP_ACC;
        end
      end
      S_FIN_INIT: cmd_o.op = OP_FIN_INIT;
      S_FIN_SQ:   cmd_o.op = OP_FIN_SQ;
      S_FIN_MGO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_FIN;
      end
      S_FIN_CMP: cmd_o.op = OP_FIN_CMP;
      S_FIN_END: cmd_o.op = OP_FIN_END;
      S_XW:      cmd_o.op = OP_XW;
      S_NORM:    cmd_o.op = OP_NORM;
      S_TAY_MGO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_TAY;
      end
      S_TAY_DGO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_TAY;
      end
      S_TAY_UPD: cmd_o.op = OP_TAY_UPD;
      S_SQ_MGO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_SQ;
      end
      S_SQ_UPD: cmd_o.op = OP_SQ_UPD;
      S_SIG_DGO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DS_SIG;
      end
      S_SIL_MGO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_SIL;
      end
      S_SMAG: cmd_o.op = OP_SMAG;
      S_OUT_MGO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_FINAL;
      end
      S_OUT: if (stat_i.out_free) cmd_o.op = OP_OUT;
      default: ;
    endcase
  end

endmodule

>>> hdl/gated_rms_norm_row_top.sv
// Gated RMS normalization of one row, two passes, Q4.11 data.
// in_i: valid/ready item channel. operation 0 (accumulate) adds x*x to the row sum;
//   the accumulate item with last set computes 1/sqrt(sum/count + epsilon) and starts
//   a new row. operation 1 (apply) returns x * inv_rms * w * silu(z), saturated.
// out_o: one item per apply item, held in an output register until taken.
// cfg_i: epsilon write, taken any cycle; write it only while the block is idle.
// Throughput: accumulate items go in at one per cycle while idle. The last accumulate
//   item holds the input for a 32-step bit search, each step one 64x64 multiply through
//   the shared multiplier. An apply item holds the input too, mostly for the 24 Taylor
//   terms of exp, each a divide by the term index, plus the sigmoid divide, all on one
//   shared divider.
// While a result waits in the output register the next item is still accepted; only the
//   step that writes a new result waits for out_o to drain.
// Reset: epsilon goes to 4, the row sum, count and inv_rms go to zero, out_o empties.
module gated_rms_norm_row_top
  import grn_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  grn_in_if.sink   in_i,
  grn_cfg_if.sink  cfg_i,
  grn_out_if.source out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  grn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  grn_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .x_i         (in_i.x_value),
    .z_i         (in_i.gate_value),
    .w_i         (in_i.weight_value),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .result_o    (out_o.result_value),
    .saturated_o (out_o.saturated)
  );

`ifndef NO_ASSERTIONS
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !stat.mul_busy) else $error("multiplier started while busy");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !stat.div_busy) else $error("divider started while busy");
  a_units_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !stat.mul_busy && !stat.div_busy) else $error("ready while computing");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_OUT |-> stat.out_free) else $error("result overwrites waiting item");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import grn_pkg::*;

  typedef struct {
    oper_e       op;
    logic [15:0] x;
    logic [15:0] z;
    logic [15:0] w;
    logic        last;
  } row_item_t;

  typedef struct {
    logic [15:0] value;
    logic        sat;
  } norm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  grn_in_if  in_if();
  grn_out_if out_if();
  grn_cfg_if cfg_if();

  gated_rms_norm_row_top i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [19:0]  eps_q = EPS_RESET;
  logic [47:0]  sq_sum_q = '0;
  logic [13:0]  count_q = '0;
  logic [31:0]  inv_rms_q = '0;

  row_item_t    pending_items[$];
  norm_result_t expected_results[$];
  int           errors = 0;
  int           n_items = 0;
  int           n_results = 0;
  int           n_sat = 0;
  int           n_rows = 0;
  bit           no_idle = 1'b0;
  bit           in_took = 1'b0;
  int           in_gap = 0;
  int           out_stall = 0;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] exp_neg_q62(input logic [63:0] t);
    logic [63:0] s, sum, term;
    s = t << 46;
    sum = ONE62;
    term = ONE62;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = mul_q62(term, s) / 64'(n);
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int k = 0; k < SQUARINGS; k++) sum = mul_q62(sum, sum);
    return sum;
  endfunction

  function automatic logic [63:0] silu_mag_q40(input logic signed [15:0] z);
    logic [63:0] t, e, d, num, sig;
    logic [127:0] p;
    t = (z < 0) ? 64'(-32'(z)) : 64'(z);
    e = exp_neg_q62(t);
    d = ONE62 + e;
    num = (z >= 0) ? ONE62 : e;
    p = ({64'b0, num} << 62) / {64'b0, d};
    sig = p[63:0];
    p = {64'b0, t} * {64'b0, sig};
    p = p + (128'd1 << 32);
    return p[96:33];
  endfunction

  function automatic logic [31:0] inv_rms_of(input logic [47:0] sum, input logic [13:0] cnt,
                                               input logic [19:0] eps);
    logic [63:0] ms, c;
    logic [127:0] lim, p;
    logic [31:0] v;
    ms = 64'(sum) + 64'(eps) * 64'(cnt);
    lim = {64'b0, 50'b0, cnt} << 62;
    v = '0;
    for (int b = 31; b >= 0; b--) begin
      c = 64'(v | (32'd1 << b));
      p = {64'b0, c * c} * {64'b0, ms};
      if (p <= lim) v = c[31:0];
    end
    return v;
  endfunction

  // one input item into the predictor; apply items queue their expected result
  task automatic predict_item(input row_item_t it);
    logic signed [63:0] xw;
    logic [63:0] mag, normed, smag, hi, q;
    logic [127:0] p;
    logic neg;
    norm_result_t r;
    if (it.op == OPER_ACCUM) begin
      if (count_q < 14'(ROW_CAP)) begin
        sq_sum_q = sq_sum_q + 48'(64'(signed'(it.x)) * 64'(signed'(it.x)));
        count_q = count_q + 1'b1;
      end
      if (it.last) begin
        inv_rms_q = inv_rms_of(sq_sum_q, count_q, eps_q);
        sq_sum_q = '0;
        count_q = '0;
        n_rows++;
      end
      return;
    end
    xw = 64'(signed'(it.x)) * 64'(signed'(it.w));
    mag = (xw < 0) ? 64'(-xw) : 64'(xw);
    normed = mag * 64'(inv_rms_q);
    smag = silu_mag_q40(it.z);
    neg = (xw < 0) != signed'(it.z) < 0;
    p = {64'b0, normed} * {64'b0, smag};
    hi = p[127:64] + 64'd64;
    q = hi >> 7;
    if (q == 0) neg = 1'b0;
    r.sat = 1'b0;
    if (!neg) begin
      if (q > 64'd32767) begin
        q = 64'd32767;
        r.sat = 1'b1;
      end
      r.value = q[15:0];
    end else begin
      if (q > 64'd32768) begin
        q = 64'd32768;
        r.sat = 1'b1;
      end
      r.value = 16'(-q);
    end
    expected_results.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // monitor: both channels and the config port, sampled at the rising edge
  always @(posedge clk) begin
    norm_result_t e;
    row_item_t it;
    in_took <= in_if.valid && in_if.ready;
    if (rst_n && cfg_if.valid && cfg_if.ready) eps_q = cfg_if.data;
    if (rst_n && in_if.valid && in_if.ready) begin
      it.op = oper_e'(in_if.operation);
      it.x = in_if.x_value;
      it.z = in_if.gate_value;
      it.w = in_if.weight_value;
      it.last = in_if.last;
      predict_item(it);
      n_items++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%h sat=%b", $time,
                 out_if.result_value, out_if.saturated);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.sat) n_sat++;
        if (out_if.result_value !== e.value || out_if.saturated !== e.sat) begin
          $display("%0t: mismatch expected value=%h sat=%b actual value=%h sat=%b", $time,
                   e.value, e.sat, out_if.result_value, out_if.saturated);
          errors++;
        end
      end
    end
  end

  // driver for the item channel and the result stall
  always @(negedge clk) begin
    row_item_t it;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
      // hold until taken
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_if.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      it = pending_items.pop_front();
      in_if.valid <= 1'b1;
      in_if.operation <= it.op;
      in_if.x_value <= it.x;
      in_if.gate_value <= it.z;
      in_if.weight_value <= it.w;
      in_if.last <= it.last;
      in_gap <= pick_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  task automatic push_item(input oper_e op, input logic [15:0] x, input logic [15:0] z,
                           input logic [15:0] w, input logic last);
    row_item_t it;
    it.op = op;
    it.x = x;
    it.z = z;
    it.w = w;
    it.last = last;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] rand_q411();
    return 16'($urandom) >>> $urandom_range(0, 15) ^ (($urandom_range(1)) ? 16'hFFFF : 16'h0);
  endfunction

  task automatic push_row(input int n_acc, input int n_app);
    for (int i = 0; i < n_acc; i++)
      push_item(OPER_ACCUM, rand_q411(), rand_q411(), rand_q411(), i == n_acc - 1);
    for (int i = 0; i < n_app; i++)
      push_item(OPER_APPLY, rand_q411(), rand_q411(), rand_q411(), 1'($urandom));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(posedge clk);
    // a finishing row produces no result but keeps the block busy
    repeat (300) @(posedge clk);
  endtask

  task automatic write_eps(input logic [19:0] v);
    drain();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      int a, b;
      a = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
      b = $urandom_range(0, 5);
      // sometimes apply in the middle of a row
      if ($urandom_range(7) == 0) begin
        push_row(0, 0);
        for (int i = 0; i < a; i++) push_item(OPER_ACCUM, rand_q411(), '0, '0, 1'b0);
        push_item(OPER_APPLY, rand_q411(), rand_q411(), rand_q411(), 1'b0);
        push_item(OPER_ACCUM, rand_q411(), '0, '0, 1'b1);
        cnt += a + 2;
      end else begin
        push_row(a, b);
        cnt += a + b;
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = OPER_ACCUM;
    in_if.x_value = '0;
    in_if.gate_value = '0;
    in_if.weight_value = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // apply before any row: inverse rms still zero
    push_item(OPER_APPLY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    push_item(OPER_ACCUM, 16'h8000, '0, '0, 1'b0);
    push_item(OPER_ACCUM, 16'h7FFF, '0, '0, 1'b0);
    push_item(OPER_ACCUM, 16'h0000, '0, '0, 1'b1);
    push_item(OPER_APPLY, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    push_item(OPER_APPLY, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    push_item(OPER_APPLY, 16'h0800, 16'h0000, 16'h0800, 1'b0);
    push_item(OPER_APPLY, 16'hF800, 16'h0800, 16'h0800, 1'b0);
    push_item(OPER_APPLY, 16'h0800, 16'hF800, 16'hF800, 1'b0);
    // apply in the middle of a row
    push_item(OPER_ACCUM, 16'h0400, '0, '0, 1'b0);
    push_item(OPER_APPLY, 16'h0400, 16'h1000, 16'h0800, 1'b0);
    push_item(OPER_ACCUM, 16'h0001, '0, '0, 1'b1);
    push_item(OPER_APPLY, 16'h0001, 16'h0001, 16'h0001, 1'b0);
    write_eps(20'd0);
    // zero mean square: inverse rms saturates
    push_item(OPER_ACCUM, 16'h0000, '0, '0, 1'b0);
    push_item(OPER_ACCUM, 16'h0000, '0, '0, 1'b1);
    push_item(OPER_APPLY, 16'h0001, 16'h7FFF, 16'h0001, 1'b0);
    push_item(OPER_APPLY, 16'hFFFF, 16'h7FFF, 16'h0001, 1'b0);
    push_item(OPER_APPLY, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b0);
    write_eps(20'hFFFFF);
    push_item(OPER_ACCUM, 16'h0001, '0, '0, 1'b1);
    push_item(OPER_APPLY, 16'h7FFF, 16'h4000, 16'h7FFF, 1'b0);

    no_idle = 1'b1;
    random_phase(300);
    write_eps(20'd0);
    no_idle = 1'b0;
    random_phase(300);
    write_eps(20'($urandom));
    random_phase(300);
    write_eps(EPS_RESET);
    random_phase(300);
    write_eps(20'hFFFFF);
    random_phase(300);
    drain();

    $display("Covered %0d items in %0d rows, %0d results checked (%0d saturated).",
             n_items, n_rows, n_results, n_sat);
    $display("Epsilon swept over zero, reset value, maximum and a random value.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("Timeout at %0t", $time);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> gated_rms_norm_row_top.f
hdl/grn_pkg.sv
hdl/grn_in_if.sv
hdl/grn_out_if.sv
hdl/grn_cfg_if.sv
hdl/grn_mul.sv
hdl/grn_div.sv
hdl/grn_datapath.sv
hdl/grn_ctrl.sv
hdl/gated_rms_norm_row_top.sv
bench/tb.sv
